/* src/bblc_pkg.sv */
package bblc_pkg;

    localparam int ENTRIES_DEF  = 16;
    localparam int KEY_BITS_DEF = 32;
    localparam int MIB_SHIFT    = 20;
    localparam logic [11:0] BUDGET_RESET = 12'd16;
    localparam logic [1:0]  ADDR_BUDGET  = 2'd0;

    typedef enum logic [2:0] {
        ST_HIT      = 3'd0,
        ST_INSERTED = 3'd1,
        ST_TOO_BIG  = 3'd2,
        ST_REMOVED  = 3'd3,
        ST_ABSENT   = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_EVICT,
        S_APPLY,
        S_OUT
    } t_state;

    // commands broadcast to the row of cells
    typedef enum logic [2:0] {
        CMD_NONE,
        CMD_TOUCH,
        CMD_DROP,
        CMD_AGE_ALL,
        CMD_INSERT
    } t_cmd;

    typedef struct packed {
        t_cmd        cmd;
        logic [7:0]  rank;
    } t_cell_ctl;

endpackage

/* src/bblc_if.sv */
interface bblc_req_if;
    logic        valid;
    logic        ready;
    logic        operation;
    logic [31:0] entry_key;
    logic [31:0] entry_bytes;
    modport source (output valid, operation, entry_key, entry_bytes, input ready);
    modport sink (input valid, operation, entry_key, entry_bytes, output ready);
endinterface

interface bblc_rsp_if;
    logic        valid;
    logic        ready;
    logic        result_kind;
    logic [31:0] result_key;
    logic [31:0] result_bytes;
    logic [2:0]  status;
    logic [31:0] bytes_in_use;
    logic        last;
    modport source (output valid, result_kind, result_key, result_bytes, status,
                    bytes_in_use, last, input ready);
    modport sink (input valid, result_kind, result_key, result_bytes, status,
                  bytes_in_use, last, output ready);
endinterface

/* src/bblc_cell.sv */
// one slot; compares its key on the passing probe and forwards chain data
module bblc_cell
    import bblc_pkg::*;
#(
    parameter int KEY_BITS = KEY_BITS_DEF,
    parameter int RW       = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cell_ctl           i_ctl,
    input  logic                i_sel,
    input  logic [KEY_BITS-1:0] i_new_key,
    input  logic [31:0]         i_new_bytes,
    input  logic [KEY_BITS-1:0] i_probe,
    input  logic [RW-1:0]       i_want_rank,
    input  logic                i_hit_in,
    input  logic                i_free_in,
    input  logic                i_rank_in,
    output logic                o_hit_out,
    output logic                o_free_out,
    output logic                o_rank_out,
    output logic                o_valid,
    output logic                o_match,
    output logic                o_is_rank,
    output logic [KEY_BITS-1:0] o_key,
    output logic [31:0]         o_bytes,
    output logic [RW-1:0]       o_rank
);
    logic                r_valid;
    logic [RW-1:0]       r_rank;
    logic [KEY_BITS-1:0] r_key;
    logic [31:0]         r_bytes;
    logic [RW-1:0]       w_ref;

    assign w_ref      = i_ctl.rank[RW-1:0];
    assign o_match    = r_valid && r_key == i_probe;
    assign o_is_rank  = r_valid && r_rank == i_want_rank;
    assign o_hit_out  = i_hit_in | o_match;
    assign o_rank_out = i_rank_in | o_is_rank;
    assign o_free_out = i_free_in | !r_valid;
    assign o_valid    = r_valid;
    assign o_key      = r_key;
    assign o_bytes    = r_bytes;
    assign o_rank     = r_rank;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_rank  <= '0;
        end else begin
            unique case (i_ctl.cmd)
                CMD_TOUCH: begin
                    if (i_sel) r_rank <= '0;
                    else if (r_valid && r_rank < w_ref) r_rank <= r_rank + 1'b1;
                end
                CMD_DROP: begin
                    if (i_sel) r_valid <= 1'b0;
                    else if (r_valid && r_rank > w_ref) r_rank <= r_rank - 1'b1;
                end
                CMD_AGE_ALL: begin
                    if (r_valid) r_rank <= r_rank + 1'b1;
                end
                CMD_INSERT: begin
                    if (i_sel) begin
                        r_valid <= 1'b1;
                        r_rank  <= '0;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.cmd == CMD_INSERT && i_sel) begin
            r_key   <= i_new_key;
            r_bytes <= i_new_bytes;
        end
    end
endmodule

/* src/byte_budget_lru_cache.sv */
// remove, hit and refusal give one result, after the scan, decide, apply and out states
// a miss gives one eviction notice per evicted entry before its final result
// one request at a time: the next request is taken after its last result is taken
// 16 cells each hold one slot
// reset (synchronous, active low) empties every slot, zeroes the byte total
// and sets the budget to 16 mib
module byte_budget_lru_cache
    import bblc_pkg::*;
#(
    parameter int ENTRIES  = ENTRIES_DEF,
    parameter int KEY_BITS = KEY_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    bblc_req_if.sink    i_req,
    bblc_rsp_if.source  o_rsp,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    localparam int RW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int IW = $clog2(ENTRIES);
    localparam int CW = $clog2(ENTRIES + 1);

    logic [11:0] r_budget;
    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_BUDGET) ? {20'd0, r_budget} : 32'd0;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_budget <= BUDGET_RESET;
        else if (psel && penable && pwrite && paddr == ADDR_BUDGET) r_budget <= pwdata[11:0];
    end

    t_state r_state, n_state;
    logic                r_op;
    logic [KEY_BITS-1:0] r_key;
    logic [31:0]         r_size;
    logic [31:0]         r_alloc;
    logic [CW-1:0]       r_count;
    logic                r_hit;
    logic [IW-1:0]       r_idx;
    logic [RW-1:0]       r_rank;
    logic [31:0]         r_ebytes;
    logic [IW-1:0]       r_free;
    logic                r_ov;
    logic                r_okind;
    logic [31:0]         r_okey;
    logic [31:0]         r_obytes;
    logic [2:0]          r_ostat;
    logic                r_olast;

    t_cell_ctl                w_ctl;
    logic [ENTRIES-1:0]       w_sel;
    logic [ENTRIES:0]         w_hc, w_fc, w_rc;
    logic [ENTRIES-1:0]       w_valid, w_match, w_isr;
    logic [KEY_BITS-1:0]      w_key [ENTRIES];
    logic [31:0]              w_bytes [ENTRIES];
    logic [RW-1:0]            w_rank [ENTRIES];
    logic [RW-1:0]            w_want;
    logic [KEY_BITS-1:0]      w_probe;

    assign w_hc[0] = 1'b0;
    assign w_fc[0] = 1'b0;
    assign w_rc[0] = 1'b0;
    assign w_want  = RW'(r_count - 1'b1);
    assign w_probe = (r_state == S_IDLE) ? KEY_BITS'(i_req.entry_key) : r_key;

    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        bblc_cell #(.KEY_BITS(KEY_BITS), .RW(RW)) u_cell (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(w_ctl), .i_sel(w_sel[g]),
            .i_new_key(r_key), .i_new_bytes(r_size), .i_probe(w_probe),
            .i_want_rank(w_want), .i_hit_in(w_hc[g]), .i_free_in(w_fc[g]),
            .i_rank_in(w_rc[g]), .o_hit_out(w_hc[g+1]), .o_free_out(w_fc[g+1]),
            .o_rank_out(w_rc[g+1]), .o_valid(w_valid[g]), .o_match(w_match[g]),
            .o_is_rank(w_isr[g]), .o_key(w_key[g]), .o_bytes(w_bytes[g]),
            .o_rank(w_rank[g])
        );
    end

    // first matching / free / victim cell by priority over the chain
    logic [IW-1:0] w_mi, w_fi, w_vi;
    always_comb begin
        w_mi = '0;
        w_fi = '0;
        w_vi = '0;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (w_match[i]) w_mi = IW'(i);
            if (!w_valid[i]) w_fi = IW'(i);
            if (w_isr[i]) w_vi = IW'(i);
        end
    end

    logic [32:0] w_budget, w_room;
    assign w_budget = {1'b0, r_budget, 20'd0};
    assign w_room   = ({1'b0, r_alloc} >= w_budget) ? 33'd0 : w_budget - {1'b0, r_alloc};

    assign i_req.ready = (r_state == S_IDLE) && !r_ov;
    assign o_rsp.valid = r_ov;
    assign o_rsp.result_kind  = r_okind;
    assign o_rsp.result_key   = r_okey;
    assign o_rsp.result_bytes = r_obytes;
    assign o_rsp.status       = r_ostat;
    assign o_rsp.bytes_in_use = r_alloc;
    assign o_rsp.last         = r_olast;

    logic w_fire;
    assign w_fire = o_rsp.valid && o_rsp.ready;

    always_comb begin
        n_state   = r_state;
        w_ctl.cmd = CMD_NONE;
        w_ctl.rank = 8'(r_rank);
        w_sel     = '0;
        unique case (r_state)
            S_IDLE:   if (i_req.valid && !r_ov) n_state = S_SCAN;
            S_SCAN:   n_state = S_DECIDE;
            S_DECIDE: begin
                if (!r_ov) begin
                    if (r_op || r_hit) n_state = S_APPLY;
                    else if ({1'b0, r_size} > w_budget) n_state = S_APPLY;
                    else if (r_count == '0 ||
                             ({1'b0, r_size} <= w_room && r_count < CW'(ENTRIES)))
                        n_state = S_APPLY;
                    // no cell holds the oldest rank, go on to insert
                    else if (!w_rc[ENTRIES]) n_state = S_APPLY;
                    else n_state = S_EVICT;
                end
            end
            S_EVICT: begin
                w_ctl.cmd  = CMD_DROP;
                w_ctl.rank = 8'(w_rank[w_vi]);
                w_sel[w_vi] = 1'b1;
                n_state = S_DECIDE;
            end
            S_APPLY: begin
                if (r_op) begin
                    if (r_hit) begin
                        w_ctl.cmd = CMD_DROP;
                        w_sel[r_idx] = 1'b1;
                    end
                end else if (r_hit) begin
                    w_ctl.cmd = CMD_TOUCH;
                    w_sel[r_idx] = 1'b1;
                end else if ({1'b0, r_size} <= w_budget) begin
                    w_ctl.cmd = CMD_AGE_ALL;
                end
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!r_op && !r_hit && {1'b0, r_size} <= w_budget && w_fc[ENTRIES]) begin
                    w_ctl.cmd = CMD_INSERT;
                    w_sel[w_fi] = 1'b1;
                end
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else r_state <= n_state;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov    <= 1'b0;
            r_alloc <= '0;
            r_count <= '0;
        end else begin
            if (w_fire) r_ov <= 1'b0;
            unique case (r_state)
                S_IDLE: if (i_req.valid && !r_ov) begin
                    r_op   <= i_req.operation;
                    r_key  <= KEY_BITS'(i_req.entry_key);
                    r_size <= i_req.entry_bytes;
                end
                S_SCAN: begin
                    r_hit <= w_hc[ENTRIES];
                    r_idx <= w_mi;
                    r_rank <= w_rank[w_mi];
                    r_ebytes <= w_bytes[w_mi];
                end
                S_EVICT: begin
                    r_alloc  <= r_alloc - w_bytes[w_vi];
                    r_count  <= r_count - 1'b1;
                    r_ov     <= 1'b1;
                    r_okind  <= 1'b0;
                    r_okey   <= 32'(w_key[w_vi]);
                    r_obytes <= w_bytes[w_vi];
                    r_ostat  <= ST_HIT;
                    r_olast  <= 1'b0;
                end
                S_OUT: begin
                    r_ov    <= 1'b1;
                    r_okind <= 1'b1;
                    r_okey  <= 32'(r_key);
                    r_olast <= 1'b1;
                    if (r_op) begin
                        if (r_hit) begin
                            r_alloc  <= r_alloc - r_ebytes;
                            r_count  <= r_count - 1'b1;
                            r_obytes <= r_ebytes;
                            r_ostat  <= ST_REMOVED;
                        end else begin
                            r_obytes <= '0;
                            r_ostat  <= ST_ABSENT;
                        end
                    end else if (r_hit) begin
                        r_obytes <= r_ebytes;
                        r_ostat  <= ST_HIT;
                    end else if ({1'b0, r_size} > w_budget) begin
                        r_obytes <= '0;
                        r_ostat  <= ST_TOO_BIG;
                    end else begin
                        r_obytes <= r_size;
                        r_ostat  <= ST_INSERTED;
                        if (w_fc[ENTRIES]) begin
                            r_alloc <= r_alloc + r_size;
                            r_count <= r_count + 1'b1;
                        end
                    end
                end
                default: ;
            endcase
        end
    end
endmodule

/* src/bblc_checker.sv */
module bblc_checker
    import bblc_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        req_valid,
    input logic        req_ready,
    input logic        rsp_valid,
    input logic        rsp_ready,
    input logic        rsp_kind,
    input logic        rsp_last,
    input logic [2:0]  rsp_status
);
    a_last_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rsp_valid |-> rsp_kind == rsp_last) else $error("kind and last disagree");
    a_evict_stat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rsp_valid && !rsp_kind |-> rsp_status == ST_HIT) else $error("eviction status");
    a_no_req_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rsp_valid |-> !req_ready) else $error("request taken while result pending");
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid) else $error("result dropped");
endmodule

bind byte_budget_lru_cache bblc_checker u_bblc_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .req_valid(i_req.valid), .req_ready(i_req.ready),
    .rsp_valid(o_rsp.valid), .rsp_ready(o_rsp.ready),
    .rsp_kind(o_rsp.result_kind), .rsp_last(o_rsp.last),
    .rsp_status(o_rsp.status)
);

/* tb/sv/tb.sv */
module tb;
    import bblc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS = 16;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct {
        logic        operation;
        logic [31:0] entry_key;
        logic [31:0] entry_bytes;
    } t_request;

    typedef struct {
        logic        result_kind;
        logic [31:0] result_key;
        logic [31:0] result_bytes;
        logic [2:0]  status;
        logic [31:0] bytes_in_use;
        logic        last;
    } t_result;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    bblc_req_if req_if ();
    bblc_rsp_if rsp_if ();

    byte_budget_lru_cache i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(req_if.sink), .o_rsp(rsp_if.source),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // shadow copy of the cache table
    logic [31:0] shadow_key [SLOTS];
    logic [31:0] shadow_bytes [SLOTS];
    logic        shadow_valid [SLOTS];
    logic [3:0]  shadow_rank [SLOTS];
    logic [31:0] shadow_alloc;
    logic [11:0] shadow_budget_mib;

    t_request pending_requests[$];
    t_result  expected_results[$];
    int errors = 0;
    int sent_count = 0, result_count = 0, evict_count = 0;
    int idle_cycles = 0;
    bit hold_off = 1'b0;
    bit stim_done = 1'b0;
    bit req_taken = 1'b0;
    logic [31:0] key_pool[$];

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch on %s: got %0h expected %0h (result %0d)",
                 what, got, want, result_count);
        errors++;
    endtask

    function automatic void push_result(input logic kind, input logic [31:0] key,
            input logic [31:0] bytes, input t_status st, input logic last);
        t_result r;
        r.result_kind = kind;
        r.result_key = key;
        r.result_bytes = bytes;
        r.status = st;
        r.bytes_in_use = shadow_alloc;
        r.last = last;
        expected_results = {expected_results, r};
    endfunction

    function automatic void drop_entry(input int s);
        shadow_valid[s] = 1'b0;
        for (int i = 0; i < SLOTS; i++)
            if (shadow_valid[i] && shadow_rank[i] > shadow_rank[s])
                shadow_rank[i]--;
        shadow_alloc -= shadow_bytes[s];
    endfunction

    function automatic void predict_cache(input t_request rq);
        int hit_slot;
        int used;
        int victim;
        logic [63:0] budget;
        logic [63:0] room;
        logic [31:0] vb;
        hit_slot = -1;
        budget = 64'(shadow_budget_mib) << MIB_SHIFT;
        for (int i = 0; i < SLOTS; i++)
            if (shadow_valid[i] && shadow_key[i] == rq.entry_key)
                hit_slot = i;
        if (rq.operation) begin
            if (hit_slot < 0) begin
                push_result(1'b1, rq.entry_key, '0, ST_ABSENT, 1'b1);
            end else begin
                vb = shadow_bytes[hit_slot];
                drop_entry(hit_slot);
                push_result(1'b1, rq.entry_key, vb, ST_REMOVED, 1'b1);
            end
            return;
        end
        if (hit_slot >= 0) begin
            for (int i = 0; i < SLOTS; i++)
                if (shadow_valid[i] && shadow_rank[i] < shadow_rank[hit_slot])
                    shadow_rank[i]++;
            shadow_rank[hit_slot] = 0;
            push_result(1'b1, rq.entry_key, shadow_bytes[hit_slot], ST_HIT, 1'b1);
            return;
        end
        if (64'(rq.entry_bytes) > budget) begin
            push_result(1'b1, rq.entry_key, '0, ST_TOO_BIG, 1'b1);
            return;
        end
        forever begin
            used = 0;
            for (int i = 0; i < SLOTS; i++)
                if (shadow_valid[i]) used++;
            room = (64'(shadow_alloc) >= budget) ? 64'd0 : budget - 64'(shadow_alloc);
            if (used == 0 || (64'(rq.entry_bytes) <= room && used < SLOTS))
                break;
            victim = -1;
            for (int i = 0; i < SLOTS; i++)
                if (shadow_valid[i] && int'(shadow_rank[i]) == used - 1)
                    victim = i;
            if (victim < 0)
                break;
            vb = shadow_bytes[victim];
            drop_entry(victim);
            push_result(1'b0, shadow_key[victim], vb, ST_HIT, 1'b0);
        end
        for (int i = 0; i < SLOTS; i++)
            if (shadow_valid[i]) shadow_rank[i]++;
        for (int i = 0; i < SLOTS; i++) begin
            if (!shadow_valid[i]) begin
                shadow_valid[i] = 1'b1;
                shadow_key[i] = rq.entry_key;
                shadow_bytes[i] = rq.entry_bytes;
                shadow_rank[i] = 0;
                shadow_alloc += rq.entry_bytes;
                break;
            end
        end
        push_result(1'b1, rq.entry_key, rq.entry_bytes, ST_INSERTED, 1'b1);
    endfunction

    // request acceptance, seen at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n && req_if.valid && req_if.ready) begin
            predict_cache('{req_if.operation, req_if.entry_key, req_if.entry_bytes});
            sent_count++;
            req_taken = 1'b1;
        end
    end

    // request driver
    int send_wait = 0;
    initial begin
        req_if.valid = 1'b0;
        req_if.operation = 1'b0;
        req_if.entry_key = '0;
        req_if.entry_bytes = '0;
    end
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (req_taken)
                send_wait = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 10);
            if (req_taken || !req_if.valid) begin
                req_taken = 1'b0;
                if (send_wait > 0) begin
                    send_wait--;
                    req_if.valid <= 1'b0;
                end else if (pending_requests.size() > 0) begin
                    t_request rq;
                    rq = pending_requests.pop_front();
                    req_if.valid <= 1'b1;
                    req_if.operation <= rq.operation;
                    req_if.entry_key <= rq.entry_key;
                    req_if.entry_bytes <= rq.entry_bytes;
                end else begin
                    req_if.valid <= 1'b0;
                end
            end
        end
    end

    // result receiver, with its own stall counter
    int recv_wait = 0;
    int hold_left = 0;
    initial rsp_if.ready = 1'b0;
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (hold_off) begin
                hold_off = 1'b0;
                hold_left = 300;
            end
            if (hold_left > 0) begin
                hold_left--;
                rsp_if.ready <= 1'b0;
            end else if (recv_wait > 0) begin
                recv_wait--;
                rsp_if.ready <= 1'b0;
            end else begin
                rsp_if.ready <= 1'b1;
                recv_wait = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 10);
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (rsp_if.valid && rsp_if.ready) begin
                t_result w;
                result_count++;
                if (!rsp_if.result_kind) evict_count++;
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected result key", rsp_if.result_key, '0);
                end else begin
                    w = expected_results.pop_front();
                    if (rsp_if.result_kind !== w.result_kind)
                        report_mismatch("result_kind", rsp_if.result_kind, w.result_kind);
                    if (rsp_if.result_key !== w.result_key)
                        report_mismatch("result_key", rsp_if.result_key, w.result_key);
                    if (rsp_if.result_bytes !== w.result_bytes)
                        report_mismatch("result_bytes", rsp_if.result_bytes,
                                        w.result_bytes);
                    if (rsp_if.status !== w.status)
                        report_mismatch("status", rsp_if.status, w.status);
                    if (rsp_if.bytes_in_use !== w.bytes_in_use)
                        report_mismatch("bytes_in_use", rsp_if.bytes_in_use,
                                        w.bytes_in_use);
                    if (rsp_if.last !== w.last)
                        report_mismatch("last", rsp_if.last, w.last);
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)
                || !i_rst_n || psel || (stim_done && expected_results.size() == 0))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no progress, %0d results pending",
                     expected_results.size());
            $display("tb failed");
            $finish;
        end
    end

    task automatic write_budget(input logic [11:0] mib);
        @(negedge i_clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= ADDR_BUDGET;
        pwdata <= 32'(mib);
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        shadow_budget_mib = mib;
    endtask

    task automatic wait_drained();
        while (pending_requests.size() > 0 || req_if.valid || expected_results.size() > 0)
            @(posedge i_clk);
        // a refused or absent request cannot leave work behind, but allow the tail
        repeat (50) @(posedge i_clk);
    endtask

    task automatic queue_request(input logic op, input logic [31:0] key,
                                 input logic [31:0] bytes);
        t_request rq;
        rq.operation = op;
        rq.entry_key = key;
        rq.entry_bytes = bytes;
        pending_requests = {pending_requests, rq};
        if (key_pool.size() < 24) key_pool = {key_pool, key};
    endtask

    function automatic logic [31:0] pick_key();
        if (key_pool.size() > 0 && $urandom_range(0, 3) != 0)
            return key_pool[$urandom_range(0, key_pool.size() - 1)];
        return $urandom();
    endfunction

    function automatic logic [31:0] pick_bytes(input logic [11:0] mib);
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 255);
            1: return $urandom();
            2: return 32'hFFF0_0000;
            default: return $urandom_range(0, 32'((longint'(mib) << MIB_SHIFT) / 3 + 1));
        endcase
    endfunction

    task automatic random_phase(input logic [11:0] mib, input int n);
        for (int i = 0; i < n; i++)
            queue_request($urandom_range(0, 4) == 0, pick_key(), pick_bytes(mib));
    endtask

    initial begin
        for (int i = 0; i < SLOTS; i++) begin
            shadow_valid[i] = 1'b0;
            shadow_rank[i] = '0;
            shadow_key[i] = '0;
            shadow_bytes[i] = '0;
        end
        shadow_alloc = '0;
        shadow_budget_mib = BUDGET_RESET;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed, at the reset budget
        queue_request(1'b1, 32'h0000_0000, 32'd0);
        queue_request(1'b0, 32'h0000_0000, 32'd0);
        queue_request(1'b0, 32'hFFFF_FFFF, 32'h0100_0000);
        queue_request(1'b0, 32'h1234_5678, 32'h0100_0001);
        queue_request(1'b0, 32'hFFFF_FFFF, 32'd5);
        queue_request(1'b0, 32'h0000_0000, 32'd1);
        queue_request(1'b1, 32'hFFFF_FFFF, 32'd0);
        queue_request(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        for (int i = 0; i < 17; i++)
            queue_request(1'b0, 32'hA5A5_0000 + i, 32'd1000 + i);
        wait_drained();

        // zero budget, below use, then budget raised to 1 mib
        write_budget(12'd0);
        queue_request(1'b0, 32'hBEEF_0001, 32'd1);
        queue_request(1'b0, 32'hBEEF_0002, 32'd0);
        wait_drained();
        write_budget(12'd1);
        queue_request(1'b0, 32'hBEEF_0003, 32'd4096);
        queue_request(1'b0, 32'hBEEF_0004, 32'h0010_0000);
        wait_drained();

        // receiver holds off while requests keep coming
        write_budget(12'd4);
        hold_off = 1'b1;
        random_phase(12'd4, 20);
        wait_drained();

        write_budget(12'd4095);
        random_phase(12'd4095, 30);
        wait_drained();
        write_budget(12'd2);
        random_phase(12'd2, 20);
        wait_drained();
        write_budget(12'($urandom_range(1, 4095)));
        random_phase(shadow_budget_mib, 30);
        wait_drained();
        write_budget(12'd3);
        random_phase(12'd3, 30);
        wait_drained();

        stim_done = 1'b1;
        $display("covered %0d requests, %0d results, %0d evictions, budgets 0 to 4095 mib",
                 sent_count, result_count, evict_count);
        if (errors == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end
endmodule
